// ===== sv/brc_pkg.sv =====
// brc_pkg: shared types, codes and default sizes for the byte range coverage tracker
// used by brc_cmp and byte_range_coverage_tracker; no dependencies
`default_nettype none

package brc_pkg;

  localparam int unsigned MAX_FRAGMENTS_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF   = 32;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned COUNT_W  = 5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE_NOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

  // merge kind codes
  localparam logic [KIND_W-1:0] MK_NEW       = 3'd0;
  localparam logic [KIND_W-1:0] MK_END_EXT   = 3'd1;
  localparam logic [KIND_W-1:0] MK_START_EXT = 3'd2;
  localparam logic [KIND_W-1:0] MK_BRIDGE    = 3'd3;
  localparam logic [KIND_W-1:0] MK_COVERED   = 3'd4;
  localparam logic [KIND_W-1:0] MK_NONE      = 3'd5;

  // compare unit result for one fragment against the current piece
  typedef struct packed {
    logic has_start;
    logic has_end;
    logic covered;
  } brc_hit_t;

endpackage

`default_nettype wire

// ===== sv/brc_ram.sv =====
// brc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module brc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/brc_cmp.sv =====
// brc_cmp: shared interval compare unit, checks one fragment against the piece
// depends on brc_pkg
`default_nettype none

module brc_cmp #(
  parameter int unsigned OFFSET_BITS = brc_pkg::OFFSET_BITS_DEF
) (
  input  wire logic [OFFSET_BITS-1:0] piece_start_i,
  input  wire logic [OFFSET_BITS:0]   piece_end_i,
  input  wire logic [OFFSET_BITS-1:0] frag_start_i,
  input  wire logic [OFFSET_BITS:0]   frag_end_i,
  output brc_pkg::brc_hit_t           hit_o
);

  logic [OFFSET_BITS:0] ps_ext;
  logic [OFFSET_BITS:0] fs_ext;

  assign ps_ext = {1'b0, piece_start_i};
  assign fs_ext = {1'b0, frag_start_i};

  assign hit_o.has_start = (ps_ext >= fs_ext) && (ps_ext <= frag_end_i);
  assign hit_o.has_end   = (piece_end_i >= fs_ext) && (piece_end_i <= frag_end_i);
  assign hit_o.covered   = (fs_ext >= ps_ext) && (frag_end_i <= piece_end_i);

endmodule

`default_nettype wire

// ===== sv/byte_range_coverage_tracker.sv =====
// byte_range_coverage_tracker: top level, sequencer, fragment table and result register
// depends on brc_pkg, brc_ram, brc_cmp
//
// usage:
//  s_axis carries one piece per beat: range_start and piece_length. m_axis returns one
//  result beat per piece: status, merge_kind and fragment_count. cfg_* writes the total
//  byte count; cfg_ready_o is always high. the user makes writes only while the tracker is
//  idle; the block itself does not enforce this. each piece walks the fragment table once
//  through a single compare unit, one entry per cycle from a ram with registered read,
//  then updates the table in the S_UPDATE state. s_axis_tready_o is low from accept
//  until the result is moved to the output register, so one piece is in flight at once.
//  once complete, a piece is answered as ignored without a table walk.
//  the result sits in an output register; the next piece is accepted while it waits,
//  and a stalled m_axis holds that piece's result beat until the register frees up.
//  reset clears the valid bits, the fragment count, the completion flag and the byte count;
//  the table ram is not cleared; an entry's data is only used while its valid bit is set.
`default_nettype none

module byte_range_coverage_tracker #(
  parameter int unsigned MAX_FRAGMENTS = brc_pkg::MAX_FRAGMENTS_DEF,
  parameter int unsigned OFFSET_BITS   = brc_pkg::OFFSET_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,      // total_bytes
  // piece input
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // [31:0] range_start, [63:32] piece_length
  // result output
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o   // [1:0] status, [4:2] merge_kind,
                                            // [9:5] fragment_count, [15:10] zero
);

  localparam int unsigned OffW   = OFFSET_BITS;
  localparam int unsigned IdxW   = $clog2(MAX_FRAGMENTS);
  localparam int unsigned CntW   = $clog2(MAX_FRAGMENTS + 1);
  localparam int unsigned FldW   = brc_pkg::FIELD_W;
  localparam int unsigned OutCW  = brc_pkg::COUNT_W;
  localparam int unsigned SzW    = (OFFSET_BITS + 1 > FldW) ? OFFSET_BITS + 1 : FldW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_FRAGMENTS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_OUT    = 5'b10000
  } state_e;

  // control state
  state_e                       state_q, state_d;
  logic [MAX_FRAGMENTS-1:0]     valid_q, valid_d;
  logic [CntW-1:0]              count_q, count_d;
  logic                         done_q, done_d;
  logic [FldW-1:0]              total_bytes_q, total_bytes_d;
  logic [IdxW-1:0]              addr_q, addr_d;
  logic                         proc_vld_q, proc_vld_d;
  logic                         m_vld_q, m_vld_d;

  // per piece work registers
  logic [IdxW-1:0]              proc_idx_q, proc_idx_d;
  logic [OffW-1:0]              ps_q, ps_d;
  logic [OffW:0]                pe_q, pe_d;
  logic                         lf_q, lf_d, rf_q, rf_d, sf_q, sf_d;
  logic [IdxW-1:0]              li_q, li_d, ri_q, ri_d, si_q, si_d;
  logic [OffW-1:0]              ls_q, ls_d;
  logic [OffW:0]                le_q, le_d, re_q, re_d;
  logic                         lc_q, lc_d, rc_q, rc_d;
  logic [MAX_FRAGMENTS-1:0]     cov_q, cov_d;
  logic [CntW-1:0]              cov_cnt_q, cov_cnt_d;
  logic [brc_pkg::STATUS_W-1:0] st_q, st_d, out_st_q, out_st_d;
  logic [brc_pkg::KIND_W-1:0]   mk_q, mk_d, out_mk_q, out_mk_d;
  logic [CntW-1:0]              res_cnt_q, res_cnt_d, out_cnt_q, out_cnt_d;

  // ram ports
  logic                         st_we, en_we;
  logic [IdxW-1:0]              st_waddr, en_waddr;
  logic [OffW-1:0]              st_wdata, rd_start;
  logic [OffW:0]                en_wdata, rd_end;

  brc_pkg::brc_hit_t            hit;

  // update helpers
  logic                         same_lr;
  logic [MAX_FRAGMENTS-1:0]     l_mask, r_mask, s_mask, rm_mask;
  logic [CntW-1:0]              removed, new_cnt;
  logic [OffW-1:0]              fin_start;
  logic [OffW:0]                fin_end;
  logic                         s_accept;

  brc_ram #(.WIDTH(OffW), .DEPTH(MAX_FRAGMENTS)) u_start_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(addr_q),
    .rdata_o(rd_start)
  );

  brc_ram #(.WIDTH(OffW + 1), .DEPTH(MAX_FRAGMENTS)) u_end_ram (
    .clk_i  (clk_i),
    .we_i   (en_we),
    .waddr_i(en_waddr),
    .wdata_i(en_wdata),
    .raddr_i(addr_q),
    .rdata_o(rd_end)
  );

  brc_cmp #(.OFFSET_BITS(OffW)) u_cmp (
    .piece_start_i(ps_q),
    .piece_end_i  (pe_q),
    .frag_start_i (rd_start),
    .frag_end_i   (rd_end),
    .hit_o        (hit)
  );

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {6'b0, OutCW'(out_cnt_q), out_mk_q, out_st_q};

  assign same_lr = lf_q && rf_q && (li_q == ri_q);
  assign l_mask  = lf_q ? (MAX_FRAGMENTS'(1) << li_q) : '0;
  assign r_mask  = rf_q ? (MAX_FRAGMENTS'(1) << ri_q) : '0;
  assign s_mask  = MAX_FRAGMENTS'(1) << si_q;
  assign rm_mask = cov_q & ~l_mask & ~r_mask;
  assign removed = cov_cnt_q - CntW'(lf_q && lc_q) - CntW'(rf_q && rc_q && !same_lr);

  always_comb begin
    state_d       = state_q;
    valid_d       = valid_q;
    count_d       = count_q;
    done_d        = done_q;
    total_bytes_d = total_bytes_q;
    addr_d        = addr_q;
    proc_vld_d    = 1'b0;
    m_vld_d       = m_vld_q;
    proc_idx_d    = addr_q;
    ps_d          = ps_q;
    pe_d          = pe_q;
    lf_d          = lf_q;
    rf_d          = rf_q;
    sf_d          = sf_q;
    li_d          = li_q;
    ri_d          = ri_q;
    si_d          = si_q;
    ls_d          = ls_q;
    le_d          = le_q;
    re_d          = re_q;
    lc_d          = lc_q;
    rc_d          = rc_q;
    cov_d         = cov_q;
    cov_cnt_d     = cov_cnt_q;
    st_d          = st_q;
    mk_d          = mk_q;
    res_cnt_d     = res_cnt_q;
    out_st_d      = out_st_q;
    out_mk_d      = out_mk_q;
    out_cnt_d     = out_cnt_q;
    st_we         = 1'b0;
    en_we         = 1'b0;
    st_waddr      = si_q;
    en_waddr      = si_q;
    st_wdata      = ps_q;
    en_wdata      = pe_q;
    new_cnt       = count_q;
    fin_start     = ps_q;
    fin_end       = pe_q;

    if (cfg_valid_i && cfg_ready_o) begin
      total_bytes_d = cfg_data_i;
    end

    if (m_vld_q && m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end

    // compare unit result for the entry read last cycle
    if (proc_vld_q && valid_q[proc_idx_q]) begin
      if (!lf_q && hit.has_start) begin
        lf_d = 1'b1;
        li_d = proc_idx_q;
        ls_d = rd_start;
        le_d = rd_end;
        lc_d = hit.covered;
      end
      if (!rf_q && hit.has_end) begin
        rf_d = 1'b1;
        ri_d = proc_idx_q;
        re_d = rd_end;
        rc_d = hit.covered;
      end
      if (hit.covered) begin
        cov_d[proc_idx_q] = 1'b1;
        cov_cnt_d         = cov_cnt_q + CntW'(1);
      end
    end
    if (proc_vld_q && !sf_q && (!valid_q[proc_idx_q] || hit.covered)) begin
      sf_d = 1'b1;
      si_d = proc_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          ps_d      = OffW'(s_axis_tdata_i[FldW-1:0]);
          pe_d      = {1'b0, OffW'(s_axis_tdata_i[2*FldW-1:FldW])}
                      + {1'b0, OffW'(s_axis_tdata_i[FldW-1:0])};
          lf_d      = 1'b0;
          rf_d      = 1'b0;
          sf_d      = 1'b0;
          cov_d     = '0;
          cov_cnt_d = '0;
          addr_d    = '0;
          if (done_q) begin
            st_d      = brc_pkg::ST_IGNORED;
            mk_d      = brc_pkg::MK_NONE;
            res_cnt_d = count_q;
            state_d   = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        proc_vld_d = 1'b1;
        if (addr_q == LastIdx) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + IdxW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        state_d = S_OUT;
        if (!lf_q && !rf_q) begin
          if (!sf_q) begin
            st_d      = brc_pkg::ST_DROPPED;
            mk_d      = brc_pkg::MK_NONE;
            res_cnt_d = count_q;
          end else begin
            st_we     = 1'b1;
            en_we     = 1'b1;
            mk_d      = brc_pkg::MK_NEW;
            valid_d   = (valid_q & ~rm_mask) | s_mask;
            new_cnt   = count_q - removed + CntW'(1);
          end
        end else begin
          valid_d = valid_q & ~rm_mask;
          new_cnt = count_q - removed;
          if (lf_q && rf_q && !same_lr) begin
            en_we      = 1'b1;
            en_waddr   = li_q;
            en_wdata   = re_q;
            valid_d    = valid_q & ~rm_mask & ~r_mask;
            new_cnt    = count_q - removed - CntW'(1);
            mk_d       = brc_pkg::MK_BRIDGE;
            fin_start  = ls_q;
            fin_end    = re_q;
          end else if (lf_q && rf_q) begin
            mk_d      = brc_pkg::MK_COVERED;
            fin_start = ls_q;
            fin_end   = le_q;
          end else if (lf_q) begin
            en_we     = 1'b1;
            en_waddr  = li_q;
            mk_d      = brc_pkg::MK_END_EXT;
            fin_start = ls_q;
          end else begin
            st_we    = 1'b1;
            st_waddr = ri_q;
            mk_d     = brc_pkg::MK_START_EXT;
            fin_end  = re_q;
          end
        end
        if (lf_q || rf_q || sf_q) begin
          count_d   = new_cnt;
          res_cnt_d = new_cnt;
          if (new_cnt == CntW'(1) && fin_start == '0
              && SzW'(fin_end) == SzW'(total_bytes_q)) begin
            done_d = 1'b1;
            st_d   = brc_pkg::ST_DONE_NOW;
          end else begin
            st_d = brc_pkg::ST_ACCEPTED;
          end
        end
      end
      S_OUT: begin
        if (!m_vld_q || m_axis_tready_i) begin
          m_vld_d   = 1'b1;
          out_st_d  = st_q;
          out_mk_d  = mk_q;
          out_cnt_d = res_cnt_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      valid_q       <= '0;
      count_q       <= '0;
      done_q        <= 1'b0;
      total_bytes_q <= '0;
      addr_q        <= '0;
      proc_vld_q    <= 1'b0;
      m_vld_q       <= 1'b0;
    end else begin
      state_q       <= state_d;
      valid_q       <= valid_d;
      count_q       <= count_d;
      done_q        <= done_d;
      total_bytes_q <= total_bytes_d;
      addr_q        <= addr_d;
      proc_vld_q    <= proc_vld_d;
      m_vld_q       <= m_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    proc_idx_q <= proc_idx_d;
    ps_q       <= ps_d;
    pe_q       <= pe_d;
    lf_q       <= lf_d;
    rf_q       <= rf_d;
    sf_q       <= sf_d;
    li_q       <= li_d;
    ri_q       <= ri_d;
    si_q       <= si_d;
    ls_q       <= ls_d;
    le_q       <= le_d;
    re_q       <= re_d;
    lc_q       <= lc_d;
    rc_q       <= rc_d;
    cov_q      <= cov_d;
    cov_cnt_q  <= cov_cnt_d;
    st_q       <= st_d;
    mk_q       <= mk_d;
    res_cnt_q  <= res_cnt_d;
    out_st_q   <= out_st_d;
    out_mk_q   <= out_mk_d;
    out_cnt_q  <= out_cnt_d;
  end

endmodule

`default_nettype wire
